@@ rtl/core/fir27_pkg.sv @@
// Shared constants, coefficient table and control types for the 27-tap low-pass FIR.
package fir27_pkg;

  localparam int TAP_COUNT     = 27;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 15;
  localparam int COEF_BITS     = 14;
  localparam int IDX_BITS      = $clog2(TAP_COUNT);
  localparam int TAP_GROW_BITS = $clog2(TAP_COUNT);

  typedef logic [IDX_BITS-1:0] tap_idx_t;

  localparam tap_idx_t LAST_TAP = IDX_BITS'(TAP_COUNT - 1);

  // Qualifiers that travel with each tap through the multiply-accumulate pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tap_ctl_t;

  // Q1.15 coefficients, symmetric around the center tap of 0.125.
  function automatic logic signed [COEF_BITS-1:0] tap_coef(input tap_idx_t idx);
    logic signed [COEF_BITS-1:0] c;
    unique case (idx)
      5'd0, 5'd26: c = -14'sd62;
      5'd1, 5'd25: c = -14'sd94;
      5'd2, 5'd24: c = -14'sd136;
      5'd3, 5'd23: c = -14'sd165;
      5'd4, 5'd22: c = -14'sd137;
      5'd5, 5'd21: c = 14'sd0;
      5'd6, 5'd20: c = 14'sd293;
      5'd7, 5'd19: c = 14'sd762;
      5'd8, 5'd18: c = 14'sd1392;
      5'd9, 5'd17: c = 14'sd2124;
      5'd10, 5'd16: c = 14'sd2866;
      5'd11, 5'd15: c = 14'sd3507;
      5'd12, 5'd14: c = 14'sd3942;
      5'd13: c = 14'sd4096;
      default: c = 14'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/fir27_mac.sv @@
// Shared multiply-accumulate unit: registered product, then full-precision accumulator.
module fir27_mac #(
  parameter int SAMPLE_BITS = fir27_pkg::SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fir27_pkg::tap_ctl_t                  ctl,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic signed [fir27_pkg::COEF_BITS-1:0] coef,
  output logic signed [SAMPLE_BITS+fir27_pkg::COEF_BITS+fir27_pkg::TAP_GROW_BITS-1:0] acc,
  output logic                                 done
);

  localparam int PROD_BITS = SAMPLE_BITS + fir27_pkg::COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + fir27_pkg::TAP_GROW_BITS;

  fir27_pkg::tap_ctl_t          prod_ctl;
  logic signed [PROD_BITS-1:0]  prod;

  always_ff @(posedge clk) begin
    prod <= sample * coef;
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  // The first tap of an item restarts the sum, so no separate clear cycle is needed.
  always_ff @(posedge clk) begin
    if (prod_ctl.valid) begin
      if (prod_ctl.first) begin
        acc <= ACC_BITS'(prod);
      end else begin
        acc <= acc + ACC_BITS'(prod);
      end
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_ctl.valid && prod_ctl.last;
    end
  end

endmodule

@@ rtl/core/fir_lowpass_27tap_core.sv @@
// Top level of the 27-tap symmetric low-pass FIR filter on signed Q1.15 audio.
//
// Input channel: in_valid / in_ready carry one sample_in per transfer. Output
// channel: out_valid / out_ready carry one sample_out per transfer. Every input
// transfer yields exactly one output transfer, in order.
//
// Each accepted sample is written into a 27-entry delay line, and one shared
// multiplier with an accumulator then walks the 27 taps, one tap per cycle.
// Behind the last tap come the operand registers, the product register and
// the accumulator add; the sequencer then sees the finished sum, and the
// hold state rounds and saturates it into the output register. The block
// takes no new sample while an item is in the tap walk or waits in the hold
// state, and the tap walk over the single multiplier sets the pace.
//
// The output register holds a finished result while the receiver stalls; the
// next sample may be accepted and filtered meanwhile, and its result waits
// until the held one has been transferred.
//
// Reset clears the delay line to zeros, the write slot to zero and drops
// out_valid; the block is ready in the first cycle after reset.
module fir_lowpass_27tap_core #(
  parameter int SAMPLE_BITS = fir27_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int ACC_BITS =
    SAMPLE_BITS + fir27_pkg::COEF_BITS + fir27_pkg::TAP_GROW_BITS;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(1 << (fir27_pkg::FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] SAT_MAX =
    {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_MIN =
    {{(ACC_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t                        state;
  logic signed [SAMPLE_BITS-1:0] delay_line [fir27_pkg::TAP_COUNT];
  fir27_pkg::tap_idx_t           write_slot;
  fir27_pkg::tap_idx_t           rd_idx;
  fir27_pkg::tap_idx_t           tap;

  fir27_pkg::tap_ctl_t                    tap_ctl;
  logic signed [SAMPLE_BITS-1:0]          tap_sample;
  logic signed [fir27_pkg::COEF_BITS-1:0] tap_coef_q;

  logic signed [ACC_BITS-1:0]    acc;
  logic                          acc_done;
  logic signed [ACC_BITS-1:0]    rounded;
  logic signed [ACC_BITS-1:0]    scaled;
  logic signed [SAMPLE_BITS-1:0] sat_value;
  logic                          out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Round half up, then floor by the arithmetic shift, then clamp.
  always_comb begin
    rounded = acc + ROUND_HALF;
    scaled  = rounded >>> fir27_pkg::FRAC_BITS;
    priority if (scaled > SAT_MAX) begin
      sat_value = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_MIN) begin
      sat_value = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_value = scaled[SAMPLE_BITS-1:0];
    end
  end

  // The new sample is written before the walk starts, so tap zero sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fir27_pkg::TAP_COUNT; i++) begin
        delay_line[i] <= '0;
      end
      write_slot <= '0;
    end else if (in_valid && in_ready) begin
      delay_line[write_slot] <= sample_in;
      if (write_slot == fir27_pkg::LAST_TAP) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_sample <= delay_line[rd_idx];
    tap_coef_q <= fir27_pkg::tap_coef(tap);
    if (rst) begin
      state     <= ST_IDLE;
      rd_idx    <= '0;
      tap       <= '0;
      tap_ctl   <= '0;
      out_valid <= 1'b0;
    end else begin
      tap_ctl.valid <= (state == ST_RUN);
      tap_ctl.first <= (state == ST_RUN) && (tap == '0);
      tap_ctl.last  <= (state == ST_RUN) && (tap == fir27_pkg::LAST_TAP);
      // In the hold state a free output register is reloaded instead.
      if (out_valid && out_ready && (state != ST_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rd_idx <= write_slot;
            tap    <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Walk backward in time through the circular delay line.
          if (rd_idx == '0) begin
            rd_idx <= fir27_pkg::LAST_TAP;
          end else begin
            rd_idx <= rd_idx - 1'b1;
          end
          if (tap == fir27_pkg::LAST_TAP) begin
            state <= ST_FLUSH;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (acc_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // The accumulator holds its sum until the output register is free.
          if (out_free) begin
            sample_out <= sat_value;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  fir27_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tap_ctl),
    .sample (tap_sample),
    .coef   (tap_coef_q),
    .acc    (acc),
    .done   (acc_done)
  );

endmodule

@@ rtl/core/fir27_checker.sv @@
// Port-level checks for the FIR core, attached to the top level by bind.
module fir27_checker #(
  parameter int SAMPLE_BITS = fir27_pkg::SAMPLE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [SAMPLE_BITS-1:0] sample_in,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out
);

  // Reset leaves no result pending and the input side open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("output pending or input blocked after reset");

  // The tap walk keeps the input closed until the item is finished.
  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##30 !in_ready)
    else $error("input reopened before the tap walk finished");

  // Some result, this item's or a held earlier one, is on offer after its tap walk and flush.
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##32 out_valid)
    else $error("no result on offer after an accepted sample");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("stalled result dropped or changed");

  // A waiting input transfer keeps its sample.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(sample_in)))
    else $error("waiting input dropped or changed");

endmodule

bind fir_lowpass_27tap_core fir27_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fir27_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the 27-tap low-pass FIR core, with driver, monitor and predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [fir27_pkg::SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'((1 << (fir27_pkg::SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(1 << (fir27_pkg::SAMPLE_BITS - 1));
  localparam int RANDOM_ITEMS = 1050;
  localparam int IDLE_PERCENT = 22;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t sample_out;

  fir_lowpass_27tap_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Low-pass taps in Q1.15, c[0] weighs the newest sample.
  int lowpass_taps [fir27_pkg::TAP_COUNT] = '{
    -62, -94, -136, -165, -137, 0, 293, 762, 1392, 2124, 2866, 3507, 3942,
    4096,
    3942, 3507, 2866, 2124, 1392, 762, 293, 0, -137, -165, -136, -94, -62
  };

  sample_t history [fir27_pkg::TAP_COUNT];
  int next_slot;

  sample_t pending_samples[$];
  sample_t expected_outputs[$];

  int error_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int saturated_results = 0;
  logic in_taken = 1'b0;

  // Both sides run without gaps over a stretch of the run.
  wire steady_stretch = (samples_sent >= 300) && (samples_sent < 500);

  function automatic sample_t filter_next_sample(sample_t x);
    longint acc;
    longint y;
    int idx;
    history[next_slot] = x;
    acc = 0;
    for (int i = 0; i < fir27_pkg::TAP_COUNT; i++) begin
      idx = (next_slot + fir27_pkg::TAP_COUNT - i) % fir27_pkg::TAP_COUNT;
      acc += longint'(lowpass_taps[i]) * longint'(history[idx]);
    end
    // Round half up, then clamp to the sample range.
    y = (acc + (longint'(1) << (fir27_pkg::FRAC_BITS - 1))) >>> fir27_pkg::FRAC_BITS;
    if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
    if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
    next_slot = (next_slot + 1) % fir27_pkg::TAP_COUNT;
    return sample_t'(y);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // A run that lines up with the tap signs drives the sum past full scale.
  task automatic queue_saturating_run(bit positive, int jitter);
    sample_t hi_val;
    sample_t lo_val;
    hi_val = sample_t'(int'(SAMPLE_MAX) - $urandom_range(0, jitter));
    lo_val = sample_t'(int'(SAMPLE_MIN) + $urandom_range(0, jitter));
    for (int i = 0; i < 15; i++) pending_samples.push_back(positive ? hi_val : lo_val);
    for (int i = 0; i < 6; i++) pending_samples.push_back(positive ? lo_val : hi_val);
  endtask

  task automatic queue_random_samples();
    int added;
    int kind;
    int len;
    int pick;
    sample_t v;
    added = 0;
    while (added < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) pending_samples.push_back(sample_t'($urandom));
      end else if (kind < 70) begin
        len = $urandom_range(3, 15);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 4);
          unique case (pick)
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = '0;
            3: v = '1;
            default: v = sample_t'(1);
          endcase
          pending_samples.push_back(v);
        end
      end else if (kind < 85) begin
        len = 21;
        queue_saturating_run(1'($urandom_range(0, 1)), 300);
      end else begin
        len = $urandom_range(5, 30);
        for (int i = 0; i < len; i++)
          pending_samples.push_back(sample_t'(int'($urandom_range(0, 511)) - 256));
      end
      added += len;
    end
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_samples.size() > 0 &&
            (steady_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        want = filter_next_sample(sample_in);
        if (want == SAMPLE_MAX || want == SAMPLE_MIN) saturated_results++;
        expected_outputs.push_back(want);
        samples_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected output transfer, sample_out=%0d", sample_out));
        end else begin
          want = expected_outputs.pop_front();
          if (sample_out !== want)
            report_mismatch($sformatf("result %0d: sample_out=%0d, expected %0d",
                                      results_checked, sample_out, want));
        end
        results_checked++;
      end
    end
  end

  initial begin
    for (int i = 0; i < fir27_pkg::TAP_COUNT; i++) history[i] = '0;
    next_slot = 0;

    // Impulses of both extremes, then a run that saturates the sum.
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back('0);
    queue_saturating_run(1'b1, 0);
    queue_random_samples();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() > 0 || in_valid) @(posedge clk);
    while (expected_outputs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Filtered %0d samples, checked %0d results, %0d of them clamped to full scale.",
             samples_sent, results_checked, saturated_results);
    if (error_count == 0) begin
      $display("fir_lowpass_27tap_core test passed");
    end else begin
      $display("fir_lowpass_27tap_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding.", expected_outputs.size());
    $display("fir_lowpass_27tap_core test failed");
    $finish;
  end

endmodule
